// ===== rtl/adrc_pkg.sv =====
// shared types, constants and helper functions of the discrete adrc compensator
`timescale 1ns / 1ps
`default_nettype none

package adrc_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_BITS    = 64;
    localparam int WIDE_BITS    = COEF_BITS + 4;
    localparam int CHUNK_BITS   = 32;
    localparam int A_CHUNKS     = COEF_BITS / CHUNK_BITS;
    localparam int B_CHUNKS     = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PP_COUNT     = A_CHUNKS * B_CHUNKS;
    localparam int PP_CNT_BITS  = $clog2(PP_COUNT + 2);
    localparam int PROD_BITS    = 2 * COEF_BITS;
    localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 2);
    localparam int REG_COUNT    = 5;
    localparam int PDATA_BITS   = (WORD_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB     = $clog2(PDATA_BITS / 8);
    localparam int INDEX_BITS   = $clog2(REG_COUNT);
    localparam int PADDR_BITS   = INDEX_BITS + ADDR_LSB;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    localparam logic [COEF_BITS-1:0] COEF_LIM = {2'b00, {(COEF_BITS-2){1'b1}}};
    localparam logic [COEF_BITS-1:0] TERM_LIM = {5'b00000, {(COEF_BITS-5){1'b1}}};
    localparam wide_t WIDE_POS_LIM = $signed({{(WIDE_BITS-COEF_BITS){1'b0}}, COEF_LIM});
    localparam wide_t WIDE_NEG_LIM = -WIDE_POS_LIM;
    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [INDEX_BITS-1:0] {
        REG_OBS_GAIN   = 0,
        REG_PLANT_GAIN = 1,
        REG_FB_GAIN1   = 2,
        REG_FB_GAIN2   = 3,
        REG_PERIOD     = 4
    } reg_idx_t;

    typedef struct packed {
        word_t setpoint;
        word_t measurement;
    } in_t;

    typedef struct packed {
        word_t drive;
        logic  saturated;
        logic  denominator_fault;
    } out_t;

    // micro-op sequence, in execution order
    typedef enum logic [4:0] {
        OP_P, OP_S, OP_SH, OP_PB2, OP_TH1, OP_Q, OP_BB1, OP_G2,
        OP_CA1, OP_CA2, OP_CB, OP_CC1, OP_CC2, OP_CD,
        OP_N0, OP_N1, OP_N2, OP_N3, OP_N4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_ALU, ST_CHECK,
        ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic load;
        logic mul_start;
        logic mul_wb;
        logic alu;
        logic div_start;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic cd_zero;
        logic out_full;
    } sts_t;

    function automatic wide_t widen(input coef_t x);
        return WIDE_BITS'(x);
    endfunction

    function automatic coef_t clamp_coef(input wide_t x);
        coef_t r;
        if (x > WIDE_POS_LIM) begin
            r = COEF_LIM;
        end else if (x < WIDE_NEG_LIM) begin
            r = -COEF_LIM;
        end else begin
            r = x[COEF_BITS-1:0];
        end
        return r;
    endfunction

    // x * 2^k, clamped
    function automatic coef_t scale_coef(input coef_t x, input logic [1:0] k);
        return clamp_coef(widen(x) <<< k);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/adrc_discrete_compensator.sv =====
// top level: apb register block, controller and datapath of the discrete adrc compensator
// one request is processed at a time: the shared multiplier (64x32, from 32x32 partial
//   products) is run 13 times, then the bit-serial divider; when D is zero the
//   numerator terms and the divide are skipped and a denominator fault is reported
// a new request is taken while the previous result still waits in the output register
// reset: synchronous active-low aresetn clears registers, history and control state
`timescale 1ns / 1ps
`default_nettype none

module adrc_discrete_compensator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire adrc_pkg::in_t                       s_data,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output adrc_pkg::out_t                           m_data,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [adrc_pkg::PADDR_BITS-1:0]     paddr,
    input  wire logic [adrc_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [adrc_pkg::PDATA_BITS-1:0]          prdata,
    output logic                                     pready
);

    localparam int W = adrc_pkg::WORD_BITS;

    // configuration registers
    adrc_pkg::word_t   obs_gain_reg;
    adrc_pkg::word_t   plant_gain_reg;
    adrc_pkg::word_t   fb_gain1_reg;
    adrc_pkg::word_t   fb_gain2_reg;
    logic [W-2:0]      period_reg;

    adrc_pkg::reg_idx_t reg_idx;
    logic               wr_en;
    adrc_pkg::cmd_t     cmd;
    adrc_pkg::sts_t     sts;

    // register index from the word-aligned address, low bits ignored
    assign reg_idx = adrc_pkg::reg_idx_t'(paddr[adrc_pkg::PADDR_BITS-1:adrc_pkg::ADDR_LSB]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // writes land in the access phase; unmapped indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_gain_reg   <= '0;
            plant_gain_reg <= '0;
            fb_gain1_reg   <= '0;
            fb_gain2_reg   <= '0;
            period_reg     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                adrc_pkg::REG_OBS_GAIN:   obs_gain_reg   <= pwdata[W-1:0];
                adrc_pkg::REG_PLANT_GAIN: plant_gain_reg <= pwdata[W-1:0];
                adrc_pkg::REG_FB_GAIN1:   fb_gain1_reg   <= pwdata[W-1:0];
                adrc_pkg::REG_FB_GAIN2:   fb_gain2_reg   <= pwdata[W-1:0];
                adrc_pkg::REG_PERIOD:     period_reg     <= pwdata[W-2:0];
                default:                  period_reg     <= period_reg;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (reg_idx)
            adrc_pkg::REG_OBS_GAIN:   prdata = adrc_pkg::PDATA_BITS'(obs_gain_reg);
            adrc_pkg::REG_PLANT_GAIN: prdata = adrc_pkg::PDATA_BITS'(plant_gain_reg);
            adrc_pkg::REG_FB_GAIN1:   prdata = adrc_pkg::PDATA_BITS'(fb_gain1_reg);
            adrc_pkg::REG_FB_GAIN2:   prdata = adrc_pkg::PDATA_BITS'(fb_gain2_reg);
            adrc_pkg::REG_PERIOD:     prdata = adrc_pkg::PDATA_BITS'(period_reg);
            default:                  prdata = '0;
        endcase
    end

    // sequencer: coefficient build, numerator terms, divide, commit
    adrc_ctrl u_ctrl (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, history and output register
    adrc_dp u_dp (
        .clk        (aclk),
        .rstn       (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .obs_gain   (obs_gain_reg),
        .plant_gain (plant_gain_reg),
        .fb_gain1   (fb_gain1_reg),
        .fb_gain2   (fb_gain2_reg),
        .period     (period_reg),
        .in_data    (s_data),
        .out_data   (m_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready)
    );

endmodule

`default_nettype wire

// ===== rtl/adrc_mul.sv =====
// shared fixed-point multiplier: 32x32 partial products, rounding and clamping
`timescale 1ns / 1ps
`default_nettype none

module adrc_mul (
    input  wire logic            clk,
    input  wire logic            rstn,
    input  wire logic            start,
    input  wire adrc_pkg::coef_t a,
    input  wire adrc_pkg::word_t b,
    input  wire logic            term,
    output logic                 done,
    output adrc_pkg::coef_t      res
);

    localparam int UB_BITS = adrc_pkg::B_CHUNKS * adrc_pkg::CHUNK_BITS;

    logic                                 busy_reg;
    logic [adrc_pkg::PP_CNT_BITS-1:0]     cnt_reg;
    logic [adrc_pkg::COEF_BITS-1:0]       ua_reg;
    logic [UB_BITS-1:0]                   ub_reg;
    logic                                 neg_reg;
    logic                                 term_reg;
    logic [2*adrc_pkg::CHUNK_BITS-1:0]    pp_reg;
    logic [adrc_pkg::PP_CNT_BITS-1:0]     pp_shift_reg;
    logic [adrc_pkg::PROD_BITS-1:0]       acc_reg;
    logic                                 done_reg;
    adrc_pkg::coef_t                      res_reg;

    logic [adrc_pkg::COEF_BITS-1:0]       abs_a;
    logic [adrc_pkg::WORD_BITS-1:0]       abs_b;
    logic [adrc_pkg::PP_CNT_BITS-1:0]     ia;
    logic [adrc_pkg::PP_CNT_BITS-1:0]     ib;
    logic [adrc_pkg::CHUNK_BITS-1:0]      a_sel;
    logic [adrc_pkg::CHUNK_BITS-1:0]      b_sel;
    logic [adrc_pkg::PROD_BITS-1:0]       rnd;
    logic                                 over;
    logic [adrc_pkg::COEF_BITS-1:0]       val;
    logic [adrc_pkg::COEF_BITS-1:0]       lim;
    logic [adrc_pkg::COEF_BITS-1:0]       mag;
    adrc_pkg::coef_t                      rounded;

    always_comb begin
        abs_a   = a[adrc_pkg::COEF_BITS-1] ? -a : a;
        abs_b   = b[adrc_pkg::WORD_BITS-1] ? -b : b;
        ia      = adrc_pkg::PP_CNT_BITS'(cnt_reg / adrc_pkg::B_CHUNKS);
        ib      = adrc_pkg::PP_CNT_BITS'(cnt_reg % adrc_pkg::B_CHUNKS);
        a_sel   = adrc_pkg::CHUNK_BITS'(ua_reg >> (adrc_pkg::CHUNK_BITS * ia));
        b_sel   = adrc_pkg::CHUNK_BITS'(ub_reg >> (adrc_pkg::CHUNK_BITS * ib));
        // round half away from zero on the magnitude
        rnd     = acc_reg + (adrc_pkg::PROD_BITS'(1) << (adrc_pkg::FRAC_BITS - 1));
        over    = |rnd[adrc_pkg::PROD_BITS-1:adrc_pkg::COEF_BITS+adrc_pkg::FRAC_BITS];
        val     = rnd[adrc_pkg::COEF_BITS+adrc_pkg::FRAC_BITS-1:adrc_pkg::FRAC_BITS];
        lim     = term_reg ? adrc_pkg::TERM_LIM : adrc_pkg::COEF_LIM;
        mag     = (over || (val > lim)) ? lim : val;
        rounded = neg_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == adrc_pkg::PP_CNT_BITS'(adrc_pkg::PP_COUNT + 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            ua_reg   <= abs_a;
            ub_reg   <= UB_BITS'(abs_b);
            neg_reg  <= a[adrc_pkg::COEF_BITS-1] ^ b[adrc_pkg::WORD_BITS-1];
            term_reg <= term;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg < adrc_pkg::PP_CNT_BITS'(adrc_pkg::PP_COUNT)) begin
                pp_reg       <= a_sel * b_sel;
                pp_shift_reg <= ia + ib;
            end
            if ((cnt_reg >= adrc_pkg::PP_CNT_BITS'(1))
                && (cnt_reg <= adrc_pkg::PP_CNT_BITS'(adrc_pkg::PP_COUNT))) begin
                acc_reg <= acc_reg + (adrc_pkg::PROD_BITS'(pp_reg)
                                      << (adrc_pkg::CHUNK_BITS * pp_shift_reg));
            end
            if (cnt_reg == adrc_pkg::PP_CNT_BITS'(adrc_pkg::PP_COUNT + 1)) begin
                res_reg <= rounded;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/adrc_div.sv =====
// restoring divider: one quotient bit per cycle, saturating to the word range
`timescale 1ns / 1ps
`default_nettype none

module adrc_div (
    input  wire logic            clk,
    input  wire logic            rstn,
    input  wire logic            start,
    input  wire adrc_pkg::coef_t num,
    input  wire adrc_pkg::coef_t den,
    output logic                 done,
    output adrc_pkg::word_t      drive,
    output logic                 sat
);

    localparam int CW = adrc_pkg::COEF_BITS;
    localparam int W  = adrc_pkg::WORD_BITS;
    localparam int F  = adrc_pkg::FRAC_BITS;

    logic                              busy_reg;
    logic [adrc_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic                              done_reg;
    logic [CW-1:0]                     an_reg;
    logic [CW-1:0]                     ad_reg;
    logic                              neg_reg;
    logic [CW-1:0]                     rem_reg;
    logic [W-1:0]                      low_reg;
    logic [W-1:0]                      quo_reg;
    logic                              ovf_reg;
    adrc_pkg::word_t                   drive_reg;
    logic                              sat_reg;

    logic [CW+W-1:0] an_ext;
    logic [CW+W-1:0] ad_sh;
    logic [CW+F-1:0] an_frac;
    logic [CW:0]     r2;
    logic            fit;
    logic            big;
    logic            sat_pos;
    logic            sat_neg;

    always_comb begin
        an_ext  = (CW+W)'(an_reg);
        ad_sh   = (CW+W)'(ad_reg) << (W - F);
        an_frac = {an_reg, {F{1'b0}}};
        r2      = {rem_reg, low_reg[W-1]};
        fit     = r2 >= {1'b0, ad_reg};
        big     = quo_reg[W-1] && (|quo_reg[W-2:0]);
        sat_pos = ovf_reg || quo_reg[W-1];
        sat_neg = ovf_reg || big;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == adrc_pkg::DIV_CNT_BITS'(W + 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            an_reg  <= num[CW-1] ? -num : num;
            ad_reg  <= den[CW-1] ? -den : den;
            neg_reg <= num[CW-1] ^ den[CW-1];
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                // quotient of 2^W or more always saturates
                ovf_reg <= an_ext >= ad_sh;
                rem_reg <= CW'(an_reg >> (W - F));
                low_reg <= an_frac[W-1:0];
                quo_reg <= '0;
            end else if (cnt_reg <= adrc_pkg::DIV_CNT_BITS'(W)) begin
                rem_reg <= fit ? CW'(r2 - {1'b0, ad_reg}) : r2[CW-1:0];
                low_reg <= {low_reg[W-2:0], 1'b0};
                quo_reg <= {quo_reg[W-2:0], fit};
            end else begin
                if (neg_reg) begin
                    sat_reg   <= sat_neg;
                    drive_reg <= sat_neg ? adrc_pkg::WORD_MIN : -$signed(quo_reg);
                end else begin
                    sat_reg   <= sat_pos;
                    drive_reg <= sat_pos ? adrc_pkg::WORD_MAX : $signed(quo_reg);
                end
            end
        end
    end

    assign done  = done_reg;
    assign drive = drive_reg;
    assign sat   = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/adrc_dp.sv =====
// datapath: coefficient registers, history, multiplier and divider, result register
`timescale 1ns / 1ps
`default_nettype none

module adrc_dp (
    input  wire logic                      clk,
    input  wire logic                      rstn,
    input  wire adrc_pkg::cmd_t            cmd,
    output adrc_pkg::sts_t                 sts,
    input  wire adrc_pkg::word_t           obs_gain,
    input  wire adrc_pkg::word_t           plant_gain,
    input  wire adrc_pkg::word_t           fb_gain1,
    input  wire adrc_pkg::word_t           fb_gain2,
    input  wire logic [adrc_pkg::WORD_BITS-2:0] period,
    input  wire adrc_pkg::in_t             in_data,
    output adrc_pkg::out_t                 out_data,
    output logic                           out_valid,
    input  wire logic                      out_ready
);

    localparam int W = adrc_pkg::WORD_BITS;

    adrc_pkg::word_t e_reg, e1_reg, e2_reg, u1_reg, u2_reg;
    adrc_pkg::coef_t p_reg, s_reg, sh2_reg, q_reg, t_reg, g2_reg;
    adrc_pkg::coef_t ca_reg, cb_reg, cc_reg, cd_reg, nce_reg, ncf_reg, num_reg;
    adrc_pkg::out_t  out_data_reg;
    logic            out_valid_reg;

    adrc_pkg::coef_t mul_a;
    adrc_pkg::word_t mul_b;
    logic            mul_term;
    logic            mul_done;
    adrc_pkg::coef_t mul_res;
    logic            div_done;
    adrc_pkg::word_t div_drive;
    logic            div_sat;
    adrc_pkg::word_t period_w;
    adrc_pkg::coef_t plant_c;
    logic signed [W:0] diff;
    adrc_pkg::word_t e_clamped;
    logic            cd_zero;

    always_comb begin
        period_w = adrc_pkg::word_t'({1'b0, period});
        plant_c  = adrc_pkg::COEF_BITS'(plant_gain);
        diff     = (W+1)'(in_data.setpoint) - (W+1)'(in_data.measurement);
        if (diff[W] != diff[W-1]) begin
            e_clamped = diff[W] ? adrc_pkg::WORD_MIN : adrc_pkg::WORD_MAX;
        end else begin
            e_clamped = diff[W-1:0];
        end
        cd_zero = (cd_reg == '0);
    end

    // operand select per micro-op
    always_comb begin
        mul_a    = p_reg;
        mul_b    = period_w;
        mul_term = 1'b0;
        case (cmd.op)
            adrc_pkg::OP_P: begin
                mul_a = adrc_pkg::COEF_BITS'(obs_gain);
                mul_b = plant_gain;
            end
            adrc_pkg::OP_S: begin
                mul_a = p_reg;
                mul_b = fb_gain1;
            end
            adrc_pkg::OP_SH:  mul_a = s_reg;
            adrc_pkg::OP_PB2: begin
                mul_a = p_reg;
                mul_b = fb_gain2;
            end
            adrc_pkg::OP_TH1, adrc_pkg::OP_Q, adrc_pkg::OP_G2: mul_a = t_reg;
            adrc_pkg::OP_BB1: begin
                mul_a = plant_c;
                mul_b = fb_gain1;
            end
            adrc_pkg::OP_N0: begin
                mul_a    = ca_reg;
                mul_b    = e_reg;
                mul_term = 1'b1;
            end
            adrc_pkg::OP_N1: begin
                mul_a    = cb_reg;
                mul_b    = e1_reg;
                mul_term = 1'b1;
            end
            adrc_pkg::OP_N2: begin
                mul_a    = cc_reg;
                mul_b    = e2_reg;
                mul_term = 1'b1;
            end
            adrc_pkg::OP_N3: begin
                mul_a    = nce_reg;
                mul_b    = u1_reg;
                mul_term = 1'b1;
            end
            adrc_pkg::OP_N4: begin
                mul_a    = ncf_reg;
                mul_b    = u2_reg;
                mul_term = 1'b1;
            end
            default: mul_a = p_reg;
        endcase
    end

    adrc_mul u_mul (
        .clk   (clk),
        .rstn  (rstn),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .term  (mul_term),
        .done  (mul_done),
        .res   (mul_res)
    );

    adrc_div u_div (
        .clk   (clk),
        .rstn  (rstn),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (cd_reg),
        .done  (div_done),
        .drive (div_drive),
        .sat   (div_sat)
    );

    // coefficient and numerator registers
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            e_reg <= e_clamped;
        end
        if (cmd.mul_wb) begin
            case (cmd.op)
                adrc_pkg::OP_P:   p_reg <= mul_res;
                adrc_pkg::OP_S:   s_reg <= adrc_pkg::clamp_coef(adrc_pkg::widen(mul_res)
                                     + adrc_pkg::WIDE_BITS'(fb_gain2));
                adrc_pkg::OP_SH:  sh2_reg <= adrc_pkg::scale_coef(mul_res, 2'd1);
                adrc_pkg::OP_PB2, adrc_pkg::OP_TH1, adrc_pkg::OP_BB1: t_reg <= mul_res;
                adrc_pkg::OP_Q:   q_reg <= mul_res;
                adrc_pkg::OP_G2:  g2_reg <= adrc_pkg::scale_coef(mul_res, 2'd1);
                adrc_pkg::OP_N0:  num_reg <= mul_res;
                adrc_pkg::OP_N1, adrc_pkg::OP_N2, adrc_pkg::OP_N3, adrc_pkg::OP_N4:
                    num_reg <= num_reg + mul_res;
                default: num_reg <= num_reg;
            endcase
        end
        if (cmd.alu) begin
            case (cmd.op)
                adrc_pkg::OP_CA1: ca_reg <= adrc_pkg::clamp_coef(
                    adrc_pkg::widen(adrc_pkg::scale_coef(p_reg, 2'd2))
                    + adrc_pkg::widen(sh2_reg));
                adrc_pkg::OP_CA2: ca_reg <= adrc_pkg::clamp_coef(
                    adrc_pkg::widen(ca_reg) + adrc_pkg::widen(q_reg));
                adrc_pkg::OP_CB:  cb_reg <= adrc_pkg::clamp_coef(
                    adrc_pkg::widen(adrc_pkg::scale_coef(q_reg, 2'd1))
                    - adrc_pkg::widen(adrc_pkg::scale_coef(p_reg, 2'd3)));
                adrc_pkg::OP_CC1: cc_reg <= adrc_pkg::clamp_coef(
                    adrc_pkg::widen(adrc_pkg::scale_coef(p_reg, 2'd2))
                    - adrc_pkg::widen(sh2_reg));
                adrc_pkg::OP_CC2: cc_reg <= adrc_pkg::clamp_coef(
                    adrc_pkg::widen(cc_reg) + adrc_pkg::widen(q_reg));
                adrc_pkg::OP_CD: begin
                    cd_reg  <= adrc_pkg::clamp_coef(
                        adrc_pkg::widen(adrc_pkg::scale_coef(plant_c, 2'd2))
                        + adrc_pkg::widen(g2_reg));
                    ncf_reg <= -adrc_pkg::clamp_coef(
                        adrc_pkg::widen(adrc_pkg::scale_coef(plant_c, 2'd2))
                        - adrc_pkg::widen(g2_reg));
                    nce_reg <= adrc_pkg::scale_coef(plant_c, 2'd3);
                end
                default: cd_reg <= cd_reg;
            endcase
        end
    end

    // history and result register
    always_ff @(posedge clk) begin
        if (!rstn) begin
            e1_reg        <= '0;
            e2_reg        <= '0;
            u1_reg        <= '0;
            u2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                e2_reg        <= e1_reg;
                e1_reg        <= e_reg;
                u2_reg        <= u1_reg;
                u1_reg        <= cd_zero ? '0 : div_drive;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.commit) begin
            out_data_reg.drive             <= cd_zero ? '0 : div_drive;
            out_data_reg.saturated         <= !cd_zero && div_sat;
            out_data_reg.denominator_fault <= cd_zero;
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.cd_zero  = cd_zero;
    assign sts.out_full = out_valid_reg && !out_ready;
    assign out_data     = out_data_reg;
    assign out_valid    = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/adrc_ctrl.sv =====
// controller: steps the micro-op sequence for one request
`timescale 1ns / 1ps
`default_nettype none

module adrc_ctrl (
    input  wire logic           clk,
    input  wire logic           rstn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire adrc_pkg::sts_t sts,
    output adrc_pkg::cmd_t      cmd
);

    adrc_pkg::state_t state_reg, state_next;
    adrc_pkg::op_t    op_reg, op_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= adrc_pkg::ST_IDLE;
            op_reg    <= adrc_pkg::OP_P;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            adrc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = adrc_pkg::OP_P;
                    state_next = adrc_pkg::ST_MUL_GO;
                end
            end
            adrc_pkg::ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = adrc_pkg::ST_MUL_WAIT;
            end
            adrc_pkg::ST_MUL_WAIT: begin
                if (sts.mul_done) begin
                    cmd.mul_wb = 1'b1;
                    if (op_reg == adrc_pkg::OP_G2) begin
                        op_next    = adrc_pkg::OP_CA1;
                        state_next = adrc_pkg::ST_ALU;
                    end else if (op_reg == adrc_pkg::OP_N4) begin
                        state_next = adrc_pkg::ST_DIV_GO;
                    end else begin
                        op_next    = adrc_pkg::op_t'(op_reg + 5'd1);
                        state_next = adrc_pkg::ST_MUL_GO;
                    end
                end
            end
            adrc_pkg::ST_ALU: begin
                cmd.alu = 1'b1;
                if (op_reg == adrc_pkg::OP_CD) begin
                    state_next = adrc_pkg::ST_CHECK;
                end else begin
                    op_next = adrc_pkg::op_t'(op_reg + 5'd1);
                end
            end
            adrc_pkg::ST_CHECK: begin
                if (sts.cd_zero) begin
                    state_next = adrc_pkg::ST_OUT;
                end else begin
                    op_next    = adrc_pkg::OP_N0;
                    state_next = adrc_pkg::ST_MUL_GO;
                end
            end
            adrc_pkg::ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = adrc_pkg::ST_DIV_WAIT;
            end
            adrc_pkg::ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = adrc_pkg::ST_OUT;
                end
            end
            adrc_pkg::ST_OUT: begin
                if (!sts.out_full) begin
                    cmd.commit = 1'b1;
                    state_next = adrc_pkg::ST_IDLE;
                end
            end
            default: state_next = adrc_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/adrc_checker.sv =====
// port-level checker for the discrete adrc compensator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module adrc_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire adrc_pkg::out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a fault result carries zero drive and no saturation
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.denominator_fault |-> m_data.drive == '0 && !m_data.saturated)
        else $error("fault result with nonzero drive or saturation");

    // a saturated drive sits on a rail
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated
        |-> m_data.drive == adrc_pkg::WORD_MAX || m_data.drive == adrc_pkg::WORD_MIN)
        else $error("saturated drive off the rails");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

endmodule

bind adrc_discrete_compensator adrc_checker u_adrc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench of the discrete adrc compensator
`timescale 1ns / 1ps

module testbench;

    localparam longint COEF_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint TERM_MAX = 64'sh07FF_FFFF_FFFF_FFFF;
    localparam int     SETTLE_CYCLES = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    adrc_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    adrc_pkg::out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [adrc_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [adrc_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic [adrc_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    // testbench copy of registers and history
    longint gain_b1, gain_b, gain_b01, gain_b02, period_h;
    longint err_z1, err_z2, drv_z1, drv_z2;

    adrc_pkg::out_t drive_queue[$];
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    adrc_discrete_compensator dut (.*);

    always #2 aclk = ~aclk;

    function automatic longint clip(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint times_k(longint x, longint k);
        longint bound;
        bound = COEF_MAX / k;
        if (x > bound) return COEF_MAX;
        if (x < -bound) return -COEF_MAX;
        return x * k;
    endfunction

    // fixed-point product, rounded half away from zero, clamped
    function automatic longint fx_mul(longint a, longint b, longint lim);
        logic [127:0] prod;
        logic [63:0]  ua, ub;
        logic         neg;
        longint       mag;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = ({64'd0, ua} * {64'd0, ub}) + (128'd1 << (adrc_pkg::FRAC_BITS - 1));
        prod = prod >> adrc_pkg::FRAC_BITS;
        if (prod > 128'(lim)) mag = lim;
        else mag = longint'(prod[63:0]);
        return neg ? -mag : mag;
    endfunction

    // computes the expected drive of one sample and advances the history
    function automatic adrc_pkg::out_t compensate(adrc_pkg::in_t smp);
        longint p, s, sh2, q, g2, ca, cb, cc, cd, ce, cf, e, num, u;
        logic [63:0] an, ad, qi, rem, mag, maxmag;
        logic neg, sat, fault;
        adrc_pkg::out_t r;
        u = 0; sat = 0; fault = 0;
        p   = fx_mul(gain_b1, gain_b, COEF_MAX);
        s   = clip(fx_mul(p, gain_b01, COEF_MAX) + gain_b02, COEF_MAX);
        sh2 = times_k(fx_mul(s, period_h, COEF_MAX), 2);
        q   = fx_mul(fx_mul(fx_mul(p, gain_b02, COEF_MAX), period_h, COEF_MAX),
                     period_h, COEF_MAX);
        ca  = clip(clip(times_k(p, 4) + sh2, COEF_MAX) + q, COEF_MAX);
        cb  = clip(times_k(q, 2) - times_k(p, 8), COEF_MAX);
        cc  = clip(clip(times_k(p, 4) - sh2, COEF_MAX) + q, COEF_MAX);
        g2  = times_k(fx_mul(fx_mul(gain_b, gain_b01, COEF_MAX), period_h, COEF_MAX), 2);
        cd  = clip(times_k(gain_b, 4) + g2, COEF_MAX);
        ce  = -times_k(gain_b, 8);
        cf  = clip(times_k(gain_b, 4) - g2, COEF_MAX);
        e = longint'(smp.setpoint) - longint'(smp.measurement);
        e = clip(e, 64'sd2147483647);
        if (e < -64'sd2147483648) e = -64'sd2147483648;
        if (longint'(smp.setpoint) - longint'(smp.measurement) < -64'sd2147483647)
            e = longint'(smp.setpoint) - longint'(smp.measurement) < -64'sd2147483648
                ? -64'sd2147483648 : longint'(smp.setpoint) - longint'(smp.measurement);
        if (cd == 0) begin
            fault = 1;
        end else begin
            num = fx_mul(ca, e, TERM_MAX) + fx_mul(cb, err_z1, TERM_MAX)
                + fx_mul(cc, err_z2, TERM_MAX) + fx_mul(-ce, drv_z1, TERM_MAX)
                + fx_mul(-cf, drv_z2, TERM_MAX);
            neg = (num < 0) != (cd < 0);
            an = (num < 0) ? -num : num;
            ad = (cd < 0) ? -cd : cd;
            maxmag = 64'd1 << (adrc_pkg::WORD_BITS - 1);
            qi = an / ad;
            rem = an % ad;
            if (qi > (maxmag >> adrc_pkg::FRAC_BITS)) begin
                mag = maxmag;
            end else begin
                mag = qi << adrc_pkg::FRAC_BITS;
                for (int i = adrc_pkg::FRAC_BITS - 1; i >= 0; i--) begin
                    rem = rem << 1;
                    if (rem >= ad) begin
                        rem = rem - ad;
                        mag[i] = 1'b1;
                    end
                end
            end
            if (neg) begin
                if (mag > maxmag) begin
                    mag = maxmag; sat = 1;
                end else if (mag == maxmag && qi > (maxmag >> adrc_pkg::FRAC_BITS)) begin
                    sat = 1;
                end
                u = -longint'(mag);
            end else begin
                if (mag > maxmag - 1) begin
                    mag = maxmag - 1; sat = 1;
                end
                u = longint'(mag);
            end
        end
        err_z2 = err_z1; err_z1 = e;
        drv_z2 = drv_z1; drv_z1 = u;
        r.drive = adrc_pkg::word_t'(u);
        r.saturated = sat;
        r.denominator_fault = fault;
        return r;
    endfunction

    // receiver with random stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        adrc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_queue.size() == 0) begin
                $error("result with no request pending: drive %0d", m_data.drive);
                fail_count++;
            end else begin
                want = drive_queue.pop_front();
                if (m_data.drive !== want.drive) begin
                    $error("drive: expected %0d, actual %0d", want.drive, m_data.drive);
                    fail_count++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, m_data.saturated);
                    fail_count++;
                end
                if (m_data.denominator_fault !== want.denominator_fault) begin
                    $error("denominator_fault: expected %0b, actual %0b",
                           want.denominator_fault, m_data.denominator_fault);
                    fail_count++;
                end
            end
        end
    end

    // apb write: setup then access cycle
    task automatic write_reg(adrc_pkg::reg_idx_t idx, longint value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= adrc_pkg::PADDR_BITS'(idx) << adrc_pkg::ADDR_LSB;
        pwdata <= adrc_pkg::PDATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            adrc_pkg::REG_OBS_GAIN:   gain_b1  = longint'(adrc_pkg::word_t'(value));
            adrc_pkg::REG_PLANT_GAIN: gain_b   = longint'(adrc_pkg::word_t'(value));
            adrc_pkg::REG_FB_GAIN1:   gain_b01 = longint'(adrc_pkg::word_t'(value));
            adrc_pkg::REG_FB_GAIN2:   gain_b02 = longint'(adrc_pkg::word_t'(value));
            adrc_pkg::REG_PERIOD:     period_h = value & 64'h7FFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic load_gains(longint b1, longint b, longint b01, longint b02, longint h);
        write_reg(adrc_pkg::REG_OBS_GAIN, b1);
        write_reg(adrc_pkg::REG_PLANT_GAIN, b);
        write_reg(adrc_pkg::REG_FB_GAIN1, b01);
        write_reg(adrc_pkg::REG_FB_GAIN2, b02);
        write_reg(adrc_pkg::REG_PERIOD, h);
    endtask

    // send one request, predicting its result at acceptance
    task automatic send_sample(adrc_pkg::word_t sp, adrc_pkg::word_t meas);
        adrc_pkg::in_t smp;
        smp.setpoint = sp;
        smp.measurement = meas;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= smp;
        do @(posedge aclk); while (!s_ready);
        drive_queue.push_back(compensate(smp));
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain_results();
        s_valid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic adrc_pkg::word_t rand_word();
        case ($urandom_range(5))
            0: return adrc_pkg::WORD_MAX;
            1: return adrc_pkg::WORD_MIN;
            2: return adrc_pkg::word_t'($urandom_range(131072)) - 65536;
            default: return adrc_pkg::word_t'($urandom);
        endcase
    endfunction

    // extremes of the inputs, error clamping and a zero denominator
    task automatic test_directed();
        load_gains(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_8000, 32'sh0000_4000,
                   32'sh0000_0100);
        send_sample(0, 0);
        send_sample(adrc_pkg::WORD_MAX, adrc_pkg::WORD_MIN);
        send_sample(adrc_pkg::WORD_MIN, adrc_pkg::WORD_MAX);
        send_sample(adrc_pkg::WORD_MAX, 0);
        send_sample(adrc_pkg::WORD_MIN, 0);
        send_sample(32'sh0001_0000, 32'sh0000_8000);
        send_sample(-1, 1);
        send_sample(32'sh7FFF_0000, -32'sh7FFF_0000);
        drain_results();
        // huge gains drive the output into saturation
        load_gains(adrc_pkg::WORD_MAX, 1, adrc_pkg::WORD_MAX, adrc_pkg::WORD_MAX,
                   32'h7FFF_FFFF);
        send_sample(adrc_pkg::WORD_MAX, adrc_pkg::WORD_MIN);
        send_sample(adrc_pkg::WORD_MIN, adrc_pkg::WORD_MAX);
        send_sample(12345, -999);
        drain_results();
        load_gains(adrc_pkg::WORD_MIN, adrc_pkg::WORD_MIN, adrc_pkg::WORD_MIN,
                   adrc_pkg::WORD_MIN, 0);
        send_sample(adrc_pkg::WORD_MAX, adrc_pkg::WORD_MIN);
        send_sample(1, 0);
        drain_results();
        // zero plant gain: denominator fault
        write_reg(adrc_pkg::REG_PLANT_GAIN, 0);
        send_sample(adrc_pkg::WORD_MAX, adrc_pkg::WORD_MIN);
        send_sample(5, 3);
        drain_results();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        load_gains(rand_word(), $urandom_range(3) == 0 ? 0 : rand_word(),
                   rand_word(), rand_word(), $urandom_range(3) == 0 ?
                   32'h7FFF_FFFF : $urandom_range(32'h0002_0000));
        repeat (count) send_sample(rand_word(), rand_word());
        drain_results();
    endtask

    initial begin
        gain_b1 = 0; gain_b = 0; gain_b01 = 0; gain_b02 = 0; period_h = 0;
        err_z1 = 0; err_z2 = 0; drv_z1 = 0; drv_z2 = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: test_random(100, 0, 0);
                1: test_random(100, 83, 0);
                2: test_random(100, 0, 83);
                default: test_random(100, 29, 29);
            endcase
        end
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
